### src/pps_time_sync_drift_calibrator_assert.svh
// Assertion macros used by the checker file of the time synchronizer.
`ifndef PPS_TIME_SYNC_DRIFT_CALIBRATOR_ASSERT_SVH
`define PPS_TIME_SYNC_DRIFT_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PTSDC_ASSERT_IMPL(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication.
`define PTSDC_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### src/ptsdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptsdc_pkg;

    typedef enum logic [1:0] {
        KIND_PULSE = 2'd0,
        KIND_MSG   = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OUT_NONE     = 3'd0,
        OUT_NO_PULSE = 3'd1,
        OUT_TOO_OLD  = 3'd2,
        OUT_BAD_DATE = 3'd3,
        OUT_SYNCED   = 3'd4
    } outcome_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_WINDOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_SHIFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAP_FLAG     = 3'd6;

    localparam logic [20:0] NOMINAL_US = 21'd1000000;

    // floor(x / 100) = (x * 5243) >> 19 for every 12-bit x
    localparam logic [12:0] Q100_MUL   = 13'd5243;
    localparam int          Q100_SHIFT = 19;
    // (1969/4) - (1969/100) + (1969/400)
    localparam logic [31:0] LEAP_BASE  = 32'd477;
    localparam logic [31:0] EPOCH_YEAR = 32'd1970;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [31:0] stale_timeout_us;
        logic [19:0] pairing_window_us;
        logic [20:0] interval_low_us;
        logic [20:0] interval_high_us;
        logic [3:0]  smoothing_shift;
        logic [7:0]  min_samples;
        logic [1:0]  leap_flag;
    } cfg_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_fields_t;

    // one classified request handed from the front to the back
    typedef struct packed {
        logic [62:0] now_us;
        outcome_t    outcome;
        logic [62:0] pulse_time;
        logic [36:0] smoothed;
        logic [7:0]  count;
        cal_fields_t date;
    } entry_t;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [62:0] pulse_time_us;
        logic [20:0] us_per_second;
        logic        time_valid;
        logic [20:0] crystal_calibration;
        logic [1:0]  leap_out;
        logic        sync_done;
        outcome_t    outcome;
    } result_t;

    // days before the first of the month; month 0 acts as January, 13..15 as December
    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12,
            4'd13,
            4'd14,
            4'd15:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

### src/ptsdc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ptsdc_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ptsdc_pkg::entry_t push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output ptsdc_pkg::entry_t     head
);
    import ptsdc_pkg::*;

    entry_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### src/ptsdc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ptsdc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptsdc_pkg::cfg_t    cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ptsdc_pkg::kind_t   kind,
    input  wire logic [62:0]        now_us,
    input  wire ptsdc_pkg::cal_fields_t date,
    input  wire logic               date_ok,
    input  wire logic               time_ok,
    input  wire logic               q_full,
    output logic                    q_push,
    output ptsdc_pkg::entry_t       q_entry
);
    import ptsdc_pkg::*;

    logic [62:0]        last_pulse_time_reg;
    logic [62:0]        last_pulse_time_next;
    logic               pulse_seen_reg;
    logic               pulse_seen_next;
    logic               pulse_pending_reg;
    logic               pulse_pending_next;
    logic [63:0]        last_interval_reg;
    logic [63:0]        last_interval_next;
    logic               interval_known_reg;
    logic               interval_known_next;
    logic [36:0]        smoothed_reg;
    logic [36:0]        smoothed_next;
    logic [7:0]         count_reg;
    logic [7:0]         count_next;

    logic               accept;
    logic [63:0]        diff;
    logic               sample_ok;
    logic [36:0]        sample;
    logic signed [37:0] step;
    logic signed [37:0] step_sh;
    logic signed [37:0] fold_sum;
    logic [36:0]        fold_value;
    outcome_t           outcome;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    always_comb
    begin
        // signed elapsed time since the last edge; timer values are below 2^63
        diff = {1'b0, now_us} - {1'b0, last_pulse_time_reg};

        sample_ok = interval_known_reg
                 && ($signed(last_interval_reg) > $signed({43'b0, cfg.interval_low_us}))
                 && ($signed(last_interval_reg) < $signed({43'b0, cfg.interval_high_us}));
        sample    = {last_interval_reg[20:0], 16'b0};

        // arithmetic shift floors the negative step, which matches the
        // rounded-up decrement of the average
        step       = $signed({1'b0, sample}) - $signed({1'b0, smoothed_reg});
        step_sh    = step >>> cfg.smoothing_shift;
        fold_sum   = $signed({1'b0, smoothed_reg}) + step_sh;
        fold_value = (count_reg == 8'd0) ? sample : fold_sum[36:0];
    end

    always_comb
    begin
        last_pulse_time_next = last_pulse_time_reg;
        pulse_seen_next      = pulse_seen_reg;
        pulse_pending_next   = pulse_pending_reg;
        last_interval_next   = last_interval_reg;
        interval_known_next  = interval_known_reg;
        smoothed_next        = smoothed_reg;
        count_next           = count_reg;
        outcome              = OUT_NONE;

        case (kind)
            KIND_PULSE:
            begin
                if (pulse_seen_reg)
                begin
                    last_interval_next  = diff;
                    interval_known_next = 1'b1;
                end
                last_pulse_time_next = now_us;
                pulse_seen_next      = 1'b1;
                pulse_pending_next   = 1'b1;
            end
            KIND_MSG:
            begin
                if (!pulse_pending_reg)
                begin
                    outcome = OUT_NO_PULSE;
                end
                else if ($signed(diff) > $signed({44'b0, cfg.pairing_window_us}))
                begin
                    pulse_pending_next = 1'b0;
                    outcome            = OUT_TOO_OLD;
                end
                else if (!(date_ok && time_ok))
                begin
                    outcome = OUT_BAD_DATE;
                end
                else
                begin
                    if (sample_ok)
                    begin
                        smoothed_next = fold_value;
                        if (count_reg != 8'd255)
                        begin
                            count_next = count_reg + 8'd1;
                        end
                    end
                    pulse_pending_next = 1'b0;
                    outcome            = OUT_SYNCED;
                end
            end
            default:
            begin
                outcome = OUT_NONE;
            end
        endcase
    end

    always_comb
    begin
        q_entry.now_us     = now_us;
        q_entry.outcome    = outcome;
        q_entry.pulse_time = last_pulse_time_reg;
        q_entry.smoothed   = smoothed_next;
        q_entry.count      = count_next;
        q_entry.date       = date;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pulse_time_reg <= '0;
            pulse_seen_reg      <= 1'b0;
            pulse_pending_reg   <= 1'b0;
            last_interval_reg   <= '0;
            interval_known_reg  <= 1'b0;
            smoothed_reg        <= '0;
            count_reg           <= '0;
        end
        else if (accept)
        begin
            last_pulse_time_reg <= last_pulse_time_next;
            pulse_seen_reg      <= pulse_seen_next;
            pulse_pending_reg   <= pulse_pending_next;
            last_interval_reg   <= last_interval_next;
            interval_known_reg  <= interval_known_next;
            smoothed_reg        <= smoothed_next;
            count_reg           <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/ptsdc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ptsdc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ptsdc_pkg::cfg_t cfg,
    input  wire logic            q_valid,
    input  wire ptsdc_pkg::entry_t q_entry,
    output logic                 q_pop,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output ptsdc_pkg::result_t   res
);
    import ptsdc_pkg::*;

    // stage 1: quotient by 100 and rounded average
    logic          s1_valid_reg;
    entry_t        s1_entry_reg;
    logic [5:0]    s1_q100_reg;
    logic [20:0]   s1_round_reg;
    // stage 2: day count
    logic          s2_valid_reg;
    entry_t        s2_entry_reg;
    logic [31:0]   s2_days_reg;
    logic [20:0]   s2_round_reg;
    // result register
    logic          res_valid_reg;
    result_t       res_reg;
    result_t       res_next;

    logic [31:0]   synced_epoch_reg;
    logic [31:0]   synced_epoch_next;
    logic [62:0]   synced_pulse_time_reg;
    logic [62:0]   synced_pulse_time_next;
    logic [20:0]   synced_rate_reg;
    logic [20:0]   synced_rate_next;
    logic          synced_valid_reg;
    logic          synced_valid_next;

    logic          en;
    logic [24:0]   q100_prod;
    logic [37:0]   round_sum;

    logic [11:0]   year;
    logic [11:0]   rem100;
    logic          div100;
    logic          year_zero;
    logic          leap_year;
    logic [9:0]    q4m;
    logic [5:0]    q100m;
    logic [3:0]    q400m;
    logic [31:0]   days;

    logic          sync;
    logic          calib_ok;
    logic [31:0]   epoch_calc;
    logic [63:0]   age;

    assign en        = !res_valid_reg || res_ready;
    assign q_pop     = en && q_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        q100_prod = {13'b0, q_entry.date.year} * {12'b0, Q100_MUL};
        round_sum = {1'b0, q_entry.smoothed} + 38'(1 << 15);
    end

    always_comb
    begin
        year      = s1_entry_reg.date.year;
        rem100    = year - ({6'b0, s1_q100_reg} * 12'd100);
        div100    = (rem100 == 12'd0);
        year_zero = (year == 12'd0);
        leap_year = (year[1:0] == 2'b00) && (!div100 || (s1_q100_reg[1:0] == 2'b00));
        // quotients of year - 1; all zero for year 0 (C division truncates)
        q4m   = year_zero ? 10'd0 : 10'((year - 12'd1) >> 2);
        q100m = year_zero ? 6'd0 : s1_q100_reg - 6'(div100);
        q400m = q100m[5:2];
        days  = (32'(year) - EPOCH_YEAR) * 32'd365
              + 32'(q4m) - 32'(q100m) + 32'(q400m) - LEAP_BASE
              + 32'(month_start(s1_entry_reg.date.month))
              + 32'(s1_entry_reg.date.day) - 32'd1
              + 32'((s1_entry_reg.date.month > 4'd2) && leap_year);
    end

    always_comb
    begin
        sync     = (s2_entry_reg.outcome == OUT_SYNCED);
        calib_ok = (s2_entry_reg.count >= cfg.min_samples);

        epoch_calc = s2_days_reg * 32'd86400
                   + 32'(s2_entry_reg.date.hour) * 32'd3600
                   + 32'(s2_entry_reg.date.minute) * 32'd60
                   + 32'(s2_entry_reg.date.second);

        synced_epoch_next      = synced_epoch_reg;
        synced_pulse_time_next = synced_pulse_time_reg;
        synced_rate_next       = synced_rate_reg;
        synced_valid_next      = synced_valid_reg;
        if (sync)
        begin
            synced_epoch_next      = epoch_calc;
            synced_pulse_time_next = s2_entry_reg.pulse_time;
            synced_rate_next       = calib_ok ? s2_round_reg : NOMINAL_US;
            synced_valid_next      = 1'b1;
        end

        age = {1'b0, s2_entry_reg.now_us} - {1'b0, synced_pulse_time_next};

        res_next.epoch_seconds       = synced_epoch_next;
        res_next.pulse_time_us       = synced_pulse_time_next;
        res_next.us_per_second       = synced_rate_next;
        res_next.time_valid          = synced_valid_next && !age[63]
                                    && (age[62:0] < {31'b0, cfg.stale_timeout_us});
        res_next.crystal_calibration = calib_ok ? s2_round_reg : 21'd0;
        res_next.leap_out            = cfg.leap_flag;
        res_next.sync_done           = sync;
        res_next.outcome             = s2_entry_reg.outcome;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            s2_valid_reg          <= 1'b0;
            res_valid_reg         <= 1'b0;
            synced_epoch_reg      <= '0;
            synced_pulse_time_reg <= '0;
            synced_rate_reg       <= NOMINAL_US;
            synced_valid_reg      <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                synced_epoch_reg      <= synced_epoch_next;
                synced_pulse_time_reg <= synced_pulse_time_next;
                synced_rate_reg       <= synced_rate_next;
                synced_valid_reg      <= synced_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_entry_reg <= q_entry;
            s1_q100_reg  <= q100_prod[Q100_SHIFT+5:Q100_SHIFT];
            s1_round_reg <= round_sum[36:16];
            s2_entry_reg <= s1_entry_reg;
            s2_days_reg  <= days;
            s2_round_reg <= s1_round_reg;
            res_reg      <= res_next;
        end
    end

endmodule

`default_nettype wire

### src/pps_time_sync_drift_calibrator.sv
// Path: queue, back stages 1 and 2, result register, m_tvalid. Throughput: one request
// per cycle while s_tready is high; the back pipeline advances whenever its result register
// is empty or taken, and a four-entry queue absorbs output stalls before s_tready drops.
// Reset (rst_n low, asynchronous) clears all synchronizer state and returns every
// configuration register to its default.
`timescale 1ns / 1ps
`default_nettype none

module pps_time_sync_drift_calibrator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [2:0]    cfg_addr,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // now_us[62:0], year[74:63], month[78:75], day[83:79], hour[88:84],
    // minute[94:89], second[100:95], date_ok[101], time_ok[102], zero[103]
    input  wire logic [103:0]  s_tdata,
    // kind[1:0]
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // epoch_seconds[31:0], pulse_time_us[94:32], us_per_second[115:95], time_valid[116],
    // crystal_calibration[137:117], leap_out[139:138], sync_done[140], outcome[143:141]
    output logic [143:0]       m_tdata
);
    import ptsdc_pkg::*;

    cfg_t         cfg_reg;
    cal_fields_t  in_date;
    logic         q_full;
    logic         q_push;
    entry_t       q_push_entry;
    logic         q_pop;
    logic         q_not_empty;
    entry_t       q_head;
    result_t      res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stale_timeout_us  <= 32'd10000000;
            cfg_reg.pairing_window_us <= 20'd500000;
            cfg_reg.interval_low_us   <= 21'd999000;
            cfg_reg.interval_high_us  <= 21'd1001000;
            cfg_reg.smoothing_shift   <= 4'd4;
            cfg_reg.min_samples       <= 8'd4;
            cfg_reg.leap_flag         <= 2'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_STALE_TIMEOUT: cfg_reg.stale_timeout_us  <= cfg_wdata;
                CFG_PAIR_WINDOW:   cfg_reg.pairing_window_us <= cfg_wdata[19:0];
                CFG_INTERVAL_LOW:  cfg_reg.interval_low_us   <= cfg_wdata[20:0];
                CFG_INTERVAL_HIGH: cfg_reg.interval_high_us  <= cfg_wdata[20:0];
                CFG_SMOOTH_SHIFT:  cfg_reg.smoothing_shift   <= cfg_wdata[3:0];
                CFG_MIN_SAMPLES:   cfg_reg.min_samples       <= cfg_wdata[7:0];
                CFG_LEAP_FLAG:     cfg_reg.leap_flag         <= cfg_wdata[1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        in_date.year   = s_tdata[74:63];
        in_date.month  = s_tdata[78:75];
        in_date.day    = s_tdata[83:79];
        in_date.hour   = s_tdata[88:84];
        in_date.minute = s_tdata[94:89];
        in_date.second = s_tdata[100:95];
    end

    ptsdc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .kind     (kind_t'(s_tuser)),
        .now_us   (s_tdata[62:0]),
        .date     (in_date),
        .date_ok  (s_tdata[101]),
        .time_ok  (s_tdata[102]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    ptsdc_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    ptsdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_entry   (q_head),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.outcome, res.sync_done, res.leap_out, res.crystal_calibration,
                      res.time_valid, res.us_per_second, res.pulse_time_us,
                      res.epoch_seconds};

endmodule

`default_nettype wire

### src/ptsdc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pps_time_sync_drift_calibrator_assert.svh"

module ptsdc_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [143:0]  m_tdata
);
    import ptsdc_pkg::*;

    // sync flag and synced outcome always agree
    `PTSDC_ASSERT_IMPL(a_sync_matches_outcome, m_tvalid, (m_tdata[140] == (m_tdata[143:141] == OUT_SYNCED)), "sync_done disagrees with outcome")

    // a sync stores either the nominal second or the reported calibration
    `PTSDC_ASSERT_IMPL(a_sync_rate_source, m_tvalid && m_tdata[140], (m_tdata[115:95] == NOMINAL_US) || (m_tdata[115:95] == m_tdata[137:117]), "synced rate is neither nominal nor calibration")

    // the next result after a taken one keeps epoch and pulse time unless it syncs
    `PTSDC_ASSERT_IMPL(a_hold_without_sync, m_tvalid && !m_tdata[140] && $past(m_tvalid && m_tready), m_tdata[94:0] == $past(m_tdata[94:0]), "synced time changed without a sync")

    `PTSDC_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

endmodule

bind pps_time_sync_drift_calibrator ptsdc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
